@@ hdl/motor_encoder_feedback_tracker_assert.svh @@
// Assertion macros used by the tracker core (metr_core).
// Every check samples on clk and is off while rst_n is low.
`ifndef MOTOR_ENCODER_FEEDBACK_TRACKER_ASSERT_SVH
`define MOTOR_ENCODER_FEEDBACK_TRACKER_ASSERT_SVH

// Condition that must hold in the same cycle.
`define METR_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tracker check failed");

// Antecedent in this cycle, consequent in the next.
`define METR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tracker check failed");

`endif

@@ hdl/metr_pkg.sv @@
package metr_pkg;

  localparam int ID_W    = 11;
  localparam int BYTE_W  = 8;
  localparam int ANGLE_W = 16;
  localparam int SPEED_W = 16;
  localparam int CUR_W   = 19;
  localparam int TURN_W  = 24;
  localparam int TOTAL_W = 38;
  localparam int REV_SH  = 13;  // one revolution is 8192 counts

  localparam logic [ID_W-1:0] BASE_ID_RST = 11'd513;
  localparam logic signed [ANGLE_W:0] HALF_REV = 17'sd4096;

  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_OFFSET  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   frame_id;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [BYTE_W-1:0] byte3;
    logic [BYTE_W-1:0] byte4;
    logic [BYTE_W-1:0] byte5;
    logic [BYTE_W-1:0] byte6;
  } item_t;

  typedef struct packed {
    logic [1:0]                motor_index;
    logic [ANGLE_W-1:0]        rotor_angle;
    logic signed [SPEED_W-1:0] rotor_speed;
    logic [CUR_W-1:0]          current_scaled;
    logic [BYTE_W-1:0]         hall_value;
    logic signed [TURN_W-1:0]  turn_count;
    logic signed [TOTAL_W-1:0] angle_sum;
  } res_t;

endpackage

@@ hdl/motor_encoder_feedback_tracker.sv @@
// Channel  Dir  Handshake          Payload
// in_      in   tvalid/tready      tuser: op; tdata: frame_id, byte0..byte6
// out_     out  tvalid/tready      tuser: motor_index; tdata: result fields
// cfg_     in   wr_en              wr_data: base_id
//
// One item per cycle unless out_tready stalls; results pass input and output registers.
// Per-motor angle, offset and turn state updates in the cycle an item leaves
// the input register, so consecutive items for one motor chain correctly.
// A stalled output holds its result while one more item waits in the input
// register. Frames outside the motor window leave that register silently.
// Synchronous reset clears all motor state and sets base_id to 513.
module motor_encoder_feedback_tracker
  import metr_pkg::*;
#(
  parameter int NUM_MOTORS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [ID_W-1:0] cfg_wr_data,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [71:0]     in_tdata,   // frame_id, byte0 .. byte6, zero pad
  input  logic            in_tuser,   // op
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [127:0]    out_tdata,  // rotor_angle, rotor_speed, current_scaled,
                                      // hall_value, turn_count, angle_sum, pad
  output logic [1:0]      out_tuser   // motor_index
);

  logic [ID_W-1:0] base_id_r;
  logic            s1_valid_r;
  item_t           s1_item_r;
  logic            out_valid_r;
  res_t            out_res_r;
  logic            s1_adv;
  logic            hit;
  res_t            res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r <= BASE_ID_RST;
    end else if (cfg_wr_en) begin
      base_id_r <= cfg_wr_data;
    end
  end

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_item_r.op       <= op_t'(in_tuser);
      s1_item_r.frame_id <= in_tdata[10:0];
      s1_item_r.byte0    <= in_tdata[18:11];
      s1_item_r.byte1    <= in_tdata[26:19];
      s1_item_r.byte2    <= in_tdata[34:27];
      s1_item_r.byte3    <= in_tdata[42:35];
      s1_item_r.byte4    <= in_tdata[50:43];
      s1_item_r.byte5    <= in_tdata[58:51];
      s1_item_r.byte6    <= in_tdata[66:59];
    end
  end

  metr_core #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .base_id  (base_id_r),
    .item_vld (s1_valid_r),
    .item_adv (s1_adv),
    .item     (s1_item_r),
    .hit      (hit),
    .res      (res)
  );

  // Drop out-of-window items here: they never reach the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r && hit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.motor_index;
  assign out_tdata  = {7'b0, out_res_r.angle_sum, out_res_r.turn_count,
                       out_res_r.hall_value, out_res_r.current_scaled,
                       out_res_r.rotor_speed, out_res_r.rotor_angle};

endmodule

@@ hdl/metr_core.sv @@
module metr_core
  import metr_pkg::*;
#(
  parameter int NUM_MOTORS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [ID_W-1:0] base_id,
  input  logic            item_vld,
  input  logic            item_adv,
  input  item_t           item,
  output logic            hit,
  output res_t            res
);

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  logic [ANGLE_W-1:0] last_r   [NUM_MOTORS];
  logic [ANGLE_W-1:0] offset_r [NUM_MOTORS];
  logic [TURN_W-1:0]  turns_r  [NUM_MOTORS];

  logic [ID_W:0]           diff;
  logic [IDX_W-1:0]        midx;
  logic [ANGLE_W-1:0]      angle;
  logic [ANGLE_W-1:0]      last_cur;
  logic [ANGLE_W-1:0]      offset_nxt;
  logic [TURN_W-1:0]       turns_cur;
  logic [TURN_W-1:0]       turns_nxt;
  logic signed [ANGLE_W:0] step;
  logic [CUR_W-1:0]        cur_raw;
  logic [TOTAL_W-1:0]      turns_ext;
  logic                    upd_en;
  logic                    is_offset;

  // Window check: a borrow means the identifier is below the base.
  assign diff = {1'b0, item.frame_id} - {1'b0, base_id};
  assign hit  = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(NUM_MOTORS));
  assign midx = diff[IDX_W-1:0];

  assign upd_en    = item_vld && item_adv && hit;
  assign is_offset = (item.op == OP_OFFSET);
  assign angle     = {item.byte0, item.byte1};
  assign last_cur  = last_r[midx];
  assign turns_cur = turns_r[midx];
  assign step      = $signed({1'b0, angle}) - $signed({1'b0, last_cur});

  always_comb begin
    turns_nxt  = turns_cur;
    offset_nxt = offset_r[midx];
    if (is_offset) begin
      offset_nxt = angle;
    end else if (step > HALF_REV) begin
      turns_nxt = turns_cur - TURN_W'(1);
    end else if (step < -HALF_REV) begin
      turns_nxt = turns_cur + TURN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        last_r[i]   <= '0;
        offset_r[i] <= '0;
        turns_r[i]  <= '0;
      end
    end else if (upd_en) begin
      last_r[midx]   <= angle;
      offset_r[midx] <= offset_nxt;
      turns_r[midx]  <= turns_nxt;
    end
  end

  assign cur_raw   = {3'b000, item.byte4, item.byte5};
  assign turns_ext = {{(TOTAL_W-TURN_W){turns_nxt[TURN_W-1]}}, turns_nxt};

  always_comb begin
    res.motor_index    = 2'(midx);
    res.rotor_angle    = angle;
    res.rotor_speed    = is_offset ? '0 : $signed({item.byte2, item.byte3});
    res.current_scaled = is_offset ? '0 : (cur_raw << 2) + cur_raw;
    res.hall_value     = is_offset ? '0 : item.byte6;
    res.turn_count     = $signed(turns_nxt);
    // Previous angle is replaced by this angle, so use it directly.
    res.angle_sum      = $signed((turns_ext << REV_SH)
                         + {{(TOTAL_W-ANGLE_W){1'b0}}, angle}
                         - {{(TOTAL_W-ANGLE_W){1'b0}}, offset_nxt});
  end

  `include "motor_encoder_feedback_tracker_assert.svh"

  `METR_ASSERT_NEXT(a_last_follows, upd_en, last_r[$past(midx)] == $past(angle))
  `METR_ASSERT_NEXT(a_offset_keeps_turns, upd_en && is_offset,
    turns_r[$past(midx)] == $past(turns_cur))
  `METR_ASSERT_NEXT(a_turn_step, upd_en,
    (TURN_W'(turns_r[$past(midx)] - $past(turns_cur)) == '0) ||
    (TURN_W'(turns_r[$past(midx)] - $past(turns_cur)) == TURN_W'(1)) ||
    (TURN_W'(turns_r[$past(midx)] - $past(turns_cur)) == '1))
  `METR_ASSERT(a_offset_total, !(item_vld && hit && is_offset) ||
    (res.angle_sum[REV_SH-1:0] == '0))

endmodule
